/* rtl/timer_reload_from_frequency_top_macros.svh */
// ----------------------------------------------------------------------------
// Timer reload set-up: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef TIMER_RELOAD_FROM_FREQUENCY_TOP_MACROS_SVH
`define TIMER_RELOAD_FROM_FREQUENCY_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TRF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("check failed");

// The consequent holds in the cycle after the antecedent.
`define TRF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("check failed");

`endif

/* rtl/trf_pkg.sv */
// ----------------------------------------------------------------------------
// Timer reload set-up: package
// Constants and the record that travels along the divider cell rows.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

    localparam int unsigned QW = 22;
    localparam int unsigned DW = 21;
    localparam int unsigned RW = 17;

    localparam logic [QW-1:0] REF_CLOCK   = 22'd3579545;
    localparam logic [RW-1:0] RELOAD_MAX  = 17'h10000;
    localparam logic [31:0]   HZ_LOW_LIM  = 32'd18;
    localparam logic [31:0]   HZ_HIGH_LIM = 32'd1193181;
    localparam logic [31:0]   MS_SCALE    = 32'hDBB3A062;
    // Reciprocal of three scaled by 2^23, exact for values below 2^23.
    localparam logic [22:0]   RECIP3      = 23'd2796203;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] rem;
        logic [DW-1:0] div;
        logic [QW-1:0] quo;
        logic [RW-1:0] tag;
    } t_cell;

endpackage

`default_nettype wire

/* rtl/timer_reload_from_frequency_top.sv */
// ----------------------------------------------------------------------------
// Timer reload set-up: top level
// Turns a requested tick frequency into a reload value, the actual
// frequency and the tick period in milliseconds.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// request   in         i_valid / o_stall   i_requested_hz
// result    out        o_valid / i_stall   o_reload_count, o_actual_hz,
//                                          o_period_ms_whole, o_period_ms_fraction
// A new request is taken every cycle unless the result is stalled; the pipeline holds
// two rows of 22 divider cells, each row followed by a rounding multiplier.
// Reset clears all valid flags; no clearing pass is needed.
// A stalled result holds the whole pipeline, and o_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_reload_from_frequency_top_macros.svh"

module timer_reload_from_frequency_top
    import trf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_requested_hz,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_reload_count,
    output logic [20:0]      o_actual_hz,
    output logic [5:0]       o_period_ms_whole,
    output logic [31:0]      o_period_ms_fraction
);

    logic          en;
    logic          r_in_valid;
    logic [31:0]   r_hz;
    t_cell         row1_in;
    t_cell         row1_out;
    t_cell         row2_in;
    t_cell         row2_out;
    logic          r_m1_valid;
    logic [44:0]   r_m1_prod;
    logic [RW-1:0] r_m1_tag;
    logic          r_rl_valid;
    logic [RW-1:0] r_reload;
    logic          r_m2_valid;
    logic [44:0]   r_m2_prod;
    logic [48:0]   r_period;
    logic [RW-1:0] r_m2_reload;
    logic          r_out_valid;
    logic [15:0]   r_out_reload;
    logic [20:0]   r_out_actual;
    logic [5:0]    r_out_whole;
    logic [31:0]   r_out_frac;
    logic [RW-1:0] n_reload;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_m1_valid  <= 1'b0;
            r_rl_valid  <= 1'b0;
            r_m2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_in_valid  <= i_valid;
            r_m1_valid  <= row1_out.valid;
            r_rl_valid  <= r_m1_valid;
            r_m2_valid  <= row2_out.valid;
            r_out_valid <= r_m2_valid;
        end
    end

    // Out-of-range requests take a fixed reload and a harmless divisor.
    always_comb begin
        row1_in.valid = r_in_valid;
        row1_in.rem   = '0;
        row1_in.quo   = '0;
        if (r_hz <= HZ_LOW_LIM) begin
            row1_in.div = DW'(1);
            row1_in.tag = RELOAD_MAX;
        end else if (r_hz >= HZ_HIGH_LIM) begin
            row1_in.div = DW'(1);
            row1_in.tag = RW'(1);
        end else begin
            row1_in.div = r_hz[DW-1:0];
            row1_in.tag = '0;
        end
    end

    trf_div_row u_row1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cell  (row1_in),
        .o_cell  (row1_out)
    );

    // Rounding the division by three is floor((q + 1) / 3).
    assign n_reload = (r_m1_tag != '0) ? r_m1_tag : r_m1_prod[23 +: RW];

    always_comb begin
        row2_in.valid = r_rl_valid;
        row2_in.rem   = '0;
        row2_in.quo   = '0;
        row2_in.div   = DW'(r_reload);
        row2_in.tag   = r_reload;
    end

    trf_div_row u_row2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cell  (row2_in),
        .o_cell  (row2_out)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hz         <= i_requested_hz;
            r_m1_prod    <= (45'({1'b0, row1_out.quo}) + 45'd1) * 45'(RECIP3);
            r_m1_tag     <= row1_out.tag;
            r_reload     <= n_reload;
            r_m2_prod    <= (45'({1'b0, row2_out.quo}) + 45'd1) * 45'(RECIP3);
            r_period     <= 49'(row2_out.tag) * 49'(MS_SCALE);
            r_m2_reload  <= row2_out.tag;
            r_out_reload <= r_m2_reload[15:0];
            r_out_actual <= r_m2_prod[43:23];
            r_out_whole  <= r_period[47:42];
            r_out_frac   <= r_period[41:10];
        end
    end

    assign o_valid              = r_out_valid;
    assign o_reload_count       = r_out_reload;
    assign o_actual_hz          = r_out_actual;
    assign o_period_ms_whole    = r_out_whole;
    assign o_period_ms_fraction = r_out_frac;

    `TRF_ASSERT_SAME(a_max_reload, o_valid && o_reload_count == 16'd0, o_actual_hz == 21'd18 && o_period_ms_whole == 6'd54)
    `TRF_ASSERT_SAME(a_min_reload, o_valid && o_reload_count == 16'd1, o_actual_hz == 21'd1193182)
    `TRF_ASSERT_NEXT(a_row_hold, !en, $stable(row2_out.valid) && $stable(r_m1_valid))

endmodule

`default_nettype wire

/* rtl/trf_cell.sv */
// ----------------------------------------------------------------------------
// Timer reload set-up: divider cell
// One restoring step: brings in one dividend bit and yields one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_cell
    import trf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_bit,
    input  wire t_cell i_cell,
    output t_cell      o_cell
);

    t_cell         r_cell;
    t_cell         n_cell;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    always_comb begin
        shifted = {i_cell.rem, i_bit};
        diff    = shifted - {1'b0, i_cell.div};
        n_cell  = i_cell;
        if (shifted >= {1'b0, i_cell.div}) begin
            n_cell.rem = diff[DW-1:0];
            n_cell.quo = {i_cell.quo[QW-2:0], 1'b1};
        end else begin
            n_cell.rem = shifted[DW-1:0];
            n_cell.quo = {i_cell.quo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.rem <= n_cell.rem;
            r_cell.div <= n_cell.div;
            r_cell.quo <= n_cell.quo;
            r_cell.tag <= n_cell.tag;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

/* rtl/trf_div_row.sv */
// ----------------------------------------------------------------------------
// Timer reload set-up: divider row
// A row of cells dividing the reference clock by the carried divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_div_row
    import trf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_cell i_cell,
    output t_cell      o_cell
);

    t_cell chain [QW+1];

    assign chain[0] = i_cell;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        trf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_bit   (REF_CLOCK[QW-1-g]),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    assign o_cell = chain[QW];

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Timer reload set-up: testbench
// Drives requested tick frequencies into the block with random gaps on both
// channels and checks every result against an in-bench calculation of the
// reload value, the actual frequency and the 6.32 millisecond period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [15:0] reload;
        logic [20:0] actual;
        logic [5:0]  ms_whole;
        logic [31:0] ms_frac;
    } t_timing;

    localparam int unsigned HZ_FLOOR   = 18;
    localparam int unsigned HZ_CEIL    = 1193181;
    localparam int unsigned REF_HZ     = 3579545;
    localparam int unsigned RANDOM_REQ = 1130;
    localparam int unsigned LATENCY    = 50;
    localparam int unsigned WATCHDOG   = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_requested_hz = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_reload_count;
    logic [20:0] o_actual_hz;
    logic [5:0]  o_period_ms_whole;
    logic [31:0] o_period_ms_fraction;

    t_timing     pending_timing[$];
    int unsigned failures = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;
    bit          drain_done = 1'b0;

    timer_reload_from_frequency_top u_top (.*);

    always #1 i_clk = ~i_clk;

    function automatic int unsigned ref_divide_round(int unsigned divisor);
        int unsigned quo;
        int unsigned res;
        quo = REF_HZ / divisor;
        if ((REF_HZ % divisor) >= REF_HZ / 2) begin
            quo++;
        end
        res = quo / 3;
        if ((quo % 3) >= 2) begin
            res++;
        end
        return res;
    endfunction

    function automatic t_timing timing_for_hz(logic [31:0] hz);
        t_timing     t;
        int unsigned reload;
        logic [63:0] period;
        if (hz <= HZ_FLOOR) begin
            reload = 32'h10000;
        end else if (hz >= HZ_CEIL) begin
            reload = 1;
        end else begin
            reload = ref_divide_round(hz);
        end
        period = (64'(32'hDBB3A062) * 64'(reload)) >> 10;
        t.reload   = reload[15:0];
        t.actual   = 21'(ref_divide_round(reload));
        t.ms_whole = period[37:32];
        t.ms_frac  = period[31:0];
        return t;
    endfunction

    // Directed rows; a cleared typed flag means the row is checked by the predictor only.
    typedef struct {
        logic [31:0] hz;
        bit          typed;
        t_timing     want;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(logic [31:0] hz, bit typed, logic [15:0] rl, logic [20:0] act,
                           logic [5:0] whole);
        t_row r;
        r.hz = hz;
        r.typed = typed;
        r.want = timing_for_hz(hz);
        if (typed) begin
            r.want.reload = rl;
            r.want.actual = act;
            r.want.ms_whole = whole;
        end
        directed_rows.push_back(r);
    endtask

    task automatic send_request(logic [31:0] hz, t_timing want);
        i_valid <= 1'b1;
        i_requested_hz <= hz;
        pending_timing.push_back(want);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            i_requested_hz <= $urandom;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_hz();
        case ($urandom_range(9))
            0: return $urandom_range(HZ_FLOOR + 1);
            1: return $urandom;
            2: return HZ_CEIL - 2 + $urandom_range(4);
            3: return $urandom_range(HZ_CEIL + 100000, HZ_CEIL);
            4, 5: return $urandom_range(2000, 19);
            default: return $urandom_range(HZ_CEIL - 1, 19);
        endcase
    endfunction

    // Result side: random stall and field checks.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= !calm && ($urandom_range(99) < 36);
        end
    end

    always @(posedge i_clk) begin
        t_timing e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_timing.size() == 0) begin
                $error("result with nothing outstanding");
                failures++;
            end else begin
                e = pending_timing.pop_front();
                if (o_reload_count !== e.reload) begin
                    $error("reload_count expected %0d got %0d", e.reload, o_reload_count);
                    failures++;
                end
                if (o_actual_hz !== e.actual) begin
                    $error("actual_hz expected %0d got %0d", e.actual, o_actual_hz);
                    failures++;
                end
                if (o_period_ms_whole !== e.ms_whole) begin
                    $error("period_ms_whole expected %0d got %0d", e.ms_whole,
                           o_period_ms_whole);
                    failures++;
                end
                if (o_period_ms_fraction !== e.ms_frac) begin
                    $error("period_ms_fraction expected %h got %h", e.ms_frac,
                           o_period_ms_fraction);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || drain_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("[timer_reload_from_frequency_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_timing     w;
        logic [31:0] hz;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(32'd0, 1, 16'd0, 21'd18, 6'd54);
        add_row(32'd1, 1, 16'd0, 21'd18, 6'd54);
        add_row(32'd18, 1, 16'd0, 21'd18, 6'd54);
        add_row(32'd19, 0, '0, '0, '0);
        add_row(32'd100, 0, '0, '0, '0);
        add_row(32'd1000, 0, '0, '0, '0);
        add_row(32'd1193180, 0, '0, '0, '0);
        add_row(32'd1193181, 1, 16'd1, 21'd1193182, 6'd0);
        add_row(32'd1193182, 1, 16'd1, 21'd1193182, 6'd0);
        add_row(32'hFFFFFFFF, 1, 16'd1, 21'd1193182, 6'd0);
        add_row(32'h80000000, 1, 16'd1, 21'd1193182, 6'd0);
        add_row(32'h55555555, 1, 16'd1, 21'd1193182, 6'd0);
        add_row(32'h0AAAAAAA, 1, 16'd1, 21'd1193182, 6'd0);
        add_row(32'd596591, 0, '0, '0, '0);
        add_row(32'd397727, 0, '0, '0, '0);
        add_row(32'd50, 0, '0, '0, '0);
        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].hz, directed_rows[k].want);
        end

        // Hold the sender until the pipeline has fully drained.
        i_valid <= 1'b0;
        wait (pending_timing.size() == 0);
        @(negedge i_clk);

        for (int n = 0; n < RANDOM_REQ; n++) begin
            calm = (n >= 300 && n < 450);
            hz = random_hz();
            w = timing_for_hz(hz);
            send_request(hz, w);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        wait (pending_timing.size() == 0);
        drain_done = 1'b1;
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("Sent %0d requests covering both clamps and the divided range,",
                 requests_sent);
        $display("checked %0d results under random gaps and stalls.", results_seen);
        if (failures == 0 && pending_timing.size() == 0) begin
            $display("[timer_reload_from_frequency_top] OK");
        end else begin
            $display("[timer_reload_from_frequency_top] ERROR");
        end
        $finish;
    end

endmodule
